FILE: rtl/drcs_pkg.sv
// Shared types, widths and helpers for the DRCS font unit parser.
`default_nettype none

package drcs_pkg;

    localparam int DATA_W     = 8;
    localparam int LEN_W      = 24;
    localparam int CODE_W     = 16;
    localparam int BPP_W      = 4;
    localparam int WB_W       = 12;
    localparam int PROD_W     = 20;
    localparam int SIZE_W     = 17;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 88;
    localparam int M_TUSER_W  = 2;

    typedef enum logic [3:0] {
        PH_COUNT,
        PH_CODE_HI,
        PH_CODE_LO,
        PH_NFONT,
        PH_MODE,
        PH_DEPTH,
        PH_WIDTH,
        PH_HEIGHT,
        PH_CHECK,
        PH_SKIP,
        PH_GEO0,
        PH_GEO1,
        PH_GLEN_HI,
        PH_GLEN_LO,
        PH_DONE,
        PH_FAIL
    } phase_t;

    typedef enum logic [1:0] {
        KIND_FONT = 2'd0,
        KIND_OK   = 2'd1,
        KIND_ERR  = 2'd2
    } kind_t;

    typedef struct packed {
        logic  start;
        logic  step;
        logic  ld_codes;
        logic  dec_codes;
        logic  ld_fonts;
        logic  dec_fonts;
        logic  set_first;
        logic  clr_first;
        logic  ld_code_hi;
        logic  ld_code_lo;
        logic  ld_mode;
        logic  ld_depth;
        logic  ld_width;
        logic  ld_height;
        logic  ld_glen_hi;
        logic  ld_glen_lo;
        logic  ld_skip_size;
        logic  dec_skip;
        logic  out_load;
        kind_t out_kind;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
        logic first;
        logic len_zero;
        logic rem_zero;
        logic rem_last;
        logic byte_zero;
        logic byte_bitmap;
        logic codes_one;
        logic fonts_one;
        logic skip_one;
        logic first_font;
        logic glen_zero;
        logic glen_over;
        logic geom_bad;
    } dp_stat_t;

    // Bits per pixel: 1 in mode 0, else smallest b with depth + 2 <= 2^b.
    function automatic logic [BPP_W-1:0] bpp_of(input logic mode0,
                                                input logic [DATA_W-1:0] depth);
        logic [BPP_W-1:0] b;
        if (mode0)              b = 4'd1;
        else if (depth == 8'd0) b = 4'd1;
        else if (depth <= 8'd2) b = 4'd2;
        else if (depth <= 8'd6) b = 4'd3;
        else if (depth <= 8'd14) b = 4'd4;
        else if (depth <= 8'd30) b = 4'd5;
        else if (depth <= 8'd62) b = 4'd6;
        else if (depth <= 8'd126) b = 4'd7;
        else if (depth <= 8'd254) b = 4'd8;
        else                    b = 4'd9;
        return b;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/drcs_font_unit_parser.sv
// Top level of the DRCS font unit parser: controller plus datapath.
//
//  Channel  Dir  Beat contents
//  s_       in   tdata: data_byte[7:0], unit_length[31:8]; tuser: first_byte
//  m_       out  tdata: font record fields; tuser: kind (font/ok/error)
//
// One byte beat is taken per cycle unless stalled. A bitmap font's height
// beat leads to a check state that tests the registered width*height*bpp
// size against the bytes left in the unit and writes the record of a
// code's first font. s_tready is low there and while the result register
// is full and not drained. Synchronous active-low reset returns the parser
// to the code-count phase with no unit active and no result pending.
`default_nettype none

module drcs_font_unit_parser (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // [7:0] data_byte, [31:8] unit_length
    input  wire logic [drcs_pkg::S_TDATA_W-1:0]  s_tdata,
    // [0] first_byte
    input  wire logic                            s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // [15:0] char_code, [23:16] font_width, [31:24] font_height,
    // [39:32] font_depth, [43:40] bits_per_pixel, [60:44] bitmap_bytes,
    // [84:61] bitmap_offset, [87:85] zero
    output logic [drcs_pkg::M_TDATA_W-1:0]       m_tdata,
    // [1:0] kind
    output logic [drcs_pkg::M_TUSER_W-1:0]       m_tuser
);

    drcs_pkg::dp_cmd_t  cmd;
    drcs_pkg::dp_stat_t stat;

    drcs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    drcs_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

`ifndef SYNTHESIS
    a_empty_unit_err: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser && (s_tdata[31:8] == 24'd0)
        |=> m_tvalid && (m_tuser == drcs_pkg::KIND_ERR))
        else $error("empty unit did not report an error");

    a_record_geom: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == drcs_pkg::KIND_FONT)
        |-> (m_tdata[23:16] != 8'd0) && (m_tdata[31:24] != 8'd0)
            && (m_tdata[60:44] != 17'd0))
        else $error("font record with empty geometry");

    a_record_bpp: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == drcs_pkg::KIND_FONT)
        |-> (m_tdata[43:40] >= 4'd1) && (m_tdata[43:40] <= 4'd9))
        else $error("bits per pixel out of range");

    a_status_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != drcs_pkg::KIND_FONT) |-> (m_tdata == '0))
        else $error("status beat carries record data");

    a_check_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.ld_height |=> !s_tready)
        else $error("input taken during header check");
`endif

endmodule

`default_nettype wire

FILE: rtl/drcs_dp.sv
// Datapath: unit counters, header fields, pattern size and result register.
`default_nettype none

module drcs_dp (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic [drcs_pkg::S_TDATA_W-1:0]     s_tdata,
    input  wire logic                               s_tuser,
    input  wire logic                               m_tready,
    input  wire drcs_pkg::dp_cmd_t                  cmd,
    output drcs_pkg::dp_stat_t                      stat,
    output logic                                    m_tvalid,
    output logic [drcs_pkg::M_TDATA_W-1:0]          m_tdata,
    output logic [drcs_pkg::M_TUSER_W-1:0]          m_tuser
);

    logic [drcs_pkg::DATA_W-1:0]  data_b;
    logic [drcs_pkg::LEN_W-1:0]   len_in;
    logic [drcs_pkg::LEN_W-1:0]   eff_rem;
    logic [drcs_pkg::LEN_W-1:0]   rem_after;
    logic [drcs_pkg::CODE_W-1:0]  glen;
    logic [drcs_pkg::PROD_W-1:0]  prod_sum;

    logic [drcs_pkg::LEN_W-1:0]   rem_reg;
    logic [drcs_pkg::LEN_W-1:0]   pos_reg;
    logic [drcs_pkg::DATA_W-1:0]  codes_reg;
    logic [drcs_pkg::DATA_W-1:0]  fonts_reg;
    logic                         first_font_reg;
    logic [drcs_pkg::CODE_W-1:0]  code_reg;
    logic                         mode0_reg;
    logic [drcs_pkg::DATA_W-1:0]  depth_reg;
    logic [drcs_pkg::BPP_W-1:0]   bpp_reg;
    logic [drcs_pkg::DATA_W-1:0]  width_reg;
    logic [drcs_pkg::WB_W-1:0]    wb_reg;
    logic [drcs_pkg::DATA_W-1:0]  height_reg;
    logic [drcs_pkg::SIZE_W-1:0]  size_reg;
    logic [drcs_pkg::SIZE_W-1:0]  skip_reg;

    logic                         m_valid_reg;
    logic [drcs_pkg::M_TUSER_W-1:0] m_kind_reg;
    logic [drcs_pkg::M_TDATA_W-1:0] m_data_reg;

    assign data_b    = s_tdata[7:0];
    assign len_in    = s_tdata[31:8];
    assign eff_rem   = s_tuser ? len_in : rem_reg;
    assign rem_after = eff_rem - 24'd1;
    assign glen      = {skip_reg[15:8], data_b};
    assign prod_sum  = wb_reg * data_b + 20'd7;

    always_comb begin
        stat.out_free    = !m_valid_reg || m_tready;
        stat.first       = s_tuser;
        stat.len_zero    = (len_in == '0);
        stat.rem_zero    = (rem_reg == '0);
        stat.rem_last    = (eff_rem == 24'd1);
        stat.byte_zero   = (data_b == '0);
        stat.byte_bitmap = (data_b[3:1] == 3'd0);
        stat.codes_one   = (codes_reg == 8'd1);
        stat.fonts_one   = (fonts_reg == 8'd1);
        stat.skip_one    = (skip_reg == 17'd1);
        stat.first_font  = first_font_reg;
        stat.glen_zero   = (glen == '0);
        stat.glen_over   = (rem_after < {8'h00, glen});
        stat.geom_bad    = (width_reg == '0) || (height_reg == '0)
                           || (rem_reg < {7'd0, size_reg});
    end

    // Unit position and remaining count are control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg <= '0;
            pos_reg <= '0;
        end else if (cmd.step) begin
            rem_reg <= rem_after;
            pos_reg <= (cmd.start ? '0 : pos_reg) + 24'd1;
        end else if (cmd.start) begin
            rem_reg <= len_in;
            pos_reg <= '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.ld_codes)  codes_reg <= data_b;
        else if (cmd.dec_codes) codes_reg <= codes_reg - 8'd1;
        if (cmd.ld_fonts)  fonts_reg <= data_b;
        else if (cmd.dec_fonts) fonts_reg <= fonts_reg - 8'd1;
        if (cmd.set_first) first_font_reg <= 1'b1;
        else if (cmd.clr_first) first_font_reg <= 1'b0;
        if (cmd.ld_code_hi) code_reg[15:8] <= data_b;
        if (cmd.ld_code_lo) code_reg[7:0]  <= data_b;
        if (cmd.ld_mode)    mode0_reg <= (data_b[3:0] == 4'd0);
        if (cmd.ld_depth) begin
            depth_reg <= data_b;
            bpp_reg   <= drcs_pkg::bpp_of(mode0_reg, data_b);
        end
        if (cmd.ld_width) begin
            width_reg <= data_b;
            wb_reg    <= bpp_reg * data_b;
        end
        if (cmd.ld_height) begin
            height_reg <= data_b;
            size_reg   <= prod_sum[19:3];
        end
        if (cmd.ld_glen_hi)        skip_reg <= {1'b0, data_b, 8'h00};
        else if (cmd.ld_glen_lo)   skip_reg <= {1'b0, glen};
        else if (cmd.ld_skip_size) skip_reg <= size_reg;
        else if (cmd.dec_skip)     skip_reg <= skip_reg - 17'd1;
    end

    // Result register: load a record or a status beat, drop on handoff.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_kind_reg <= cmd.out_kind;
            if (cmd.out_kind == drcs_pkg::KIND_FONT) begin
                m_data_reg <= {3'b000, pos_reg, size_reg, bpp_reg, depth_reg,
                               height_reg, width_reg, code_reg};
            end else begin
                m_data_reg <= '0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_kind_reg;

endmodule

`default_nettype wire

FILE: rtl/drcs_ctrl.sv
// Controller: parse phase state machine and datapath command decode.
`default_nettype none

module drcs_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire drcs_pkg::dp_stat_t  stat,
    output drcs_pkg::dp_cmd_t        cmd
);

    drcs_pkg::phase_t state_reg;
    drcs_pkg::phase_t state_next;
    drcs_pkg::phase_t ph;
    logic             accept;
    logic             err;

    function automatic drcs_pkg::phase_t after_code(input logic codes_one);
        return codes_one ? drcs_pkg::PH_DONE : drcs_pkg::PH_CODE_HI;
    endfunction

    function automatic drcs_pkg::phase_t after_font(input logic fonts_one,
                                                    input logic codes_one);
        return fonts_one ? after_code(codes_one) : drcs_pkg::PH_MODE;
    endfunction

    assign s_tready = (state_reg != drcs_pkg::PH_CHECK) && stat.out_free;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= drcs_pkg::PH_COUNT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        ph         = state_reg;
        err        = 1'b0;
        if (state_reg == drcs_pkg::PH_CHECK) begin
            // Header check of a bitmap font, entered in the cycle after the height beat.
            if (stat.out_free) begin
                if (stat.geom_bad) begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = drcs_pkg::KIND_ERR;
                    state_next   = drcs_pkg::PH_FAIL;
                end else begin
                    cmd.out_load     = stat.first_font;
                    cmd.out_kind     = drcs_pkg::KIND_FONT;
                    cmd.clr_first    = 1'b1;
                    cmd.ld_skip_size = 1'b1;
                    state_next       = drcs_pkg::PH_SKIP;
                end
            end
        end else if (accept) begin
            if (stat.first && stat.len_zero) begin
                cmd.start    = 1'b1;
                cmd.out_load = 1'b1;
                cmd.out_kind = drcs_pkg::KIND_ERR;
                state_next   = drcs_pkg::PH_FAIL;
            end else if (stat.first || !stat.rem_zero) begin
                cmd.start = stat.first;
                cmd.step  = 1'b1;
                ph        = stat.first ? drcs_pkg::PH_COUNT : state_reg;
                state_next = ph;
                unique case (ph)
                    drcs_pkg::PH_COUNT: begin
                        cmd.ld_codes = 1'b1;
                        state_next   = stat.byte_zero ? drcs_pkg::PH_DONE
                                                      : drcs_pkg::PH_CODE_HI;
                    end
                    drcs_pkg::PH_CODE_HI: begin
                        cmd.ld_code_hi = 1'b1;
                        state_next     = drcs_pkg::PH_CODE_LO;
                    end
                    drcs_pkg::PH_CODE_LO: begin
                        cmd.ld_code_lo = 1'b1;
                        state_next     = drcs_pkg::PH_NFONT;
                    end
                    drcs_pkg::PH_NFONT: begin
                        cmd.ld_fonts  = 1'b1;
                        cmd.set_first = 1'b1;
                        if (stat.byte_zero) begin
                            cmd.dec_codes = 1'b1;
                            state_next    = after_code(stat.codes_one);
                        end else begin
                            state_next = drcs_pkg::PH_MODE;
                        end
                    end
                    drcs_pkg::PH_MODE: begin
                        cmd.ld_mode = 1'b1;
                        state_next  = stat.byte_bitmap ? drcs_pkg::PH_DEPTH
                                                       : drcs_pkg::PH_GEO0;
                    end
                    drcs_pkg::PH_DEPTH: begin
                        cmd.ld_depth = 1'b1;
                        state_next   = drcs_pkg::PH_WIDTH;
                    end
                    drcs_pkg::PH_WIDTH: begin
                        cmd.ld_width = 1'b1;
                        state_next   = drcs_pkg::PH_HEIGHT;
                    end
                    drcs_pkg::PH_HEIGHT: begin
                        cmd.ld_height = 1'b1;
                        state_next    = drcs_pkg::PH_CHECK;
                    end
                    drcs_pkg::PH_SKIP: begin
                        cmd.dec_skip = 1'b1;
                        if (stat.skip_one) begin
                            cmd.clr_first = 1'b1;
                            cmd.dec_fonts = 1'b1;
                            cmd.dec_codes = stat.fonts_one;
                            state_next    = after_font(stat.fonts_one, stat.codes_one);
                        end
                    end
                    drcs_pkg::PH_GEO0: begin
                        state_next = drcs_pkg::PH_GEO1;
                    end
                    drcs_pkg::PH_GEO1: begin
                        state_next = drcs_pkg::PH_GLEN_HI;
                    end
                    drcs_pkg::PH_GLEN_HI: begin
                        cmd.ld_glen_hi = 1'b1;
                        state_next     = drcs_pkg::PH_GLEN_LO;
                    end
                    drcs_pkg::PH_GLEN_LO: begin
                        cmd.ld_glen_lo = 1'b1;
                        if (stat.glen_over) begin
                            err = 1'b1;
                        end else if (stat.glen_zero) begin
                            cmd.clr_first = 1'b1;
                            cmd.dec_fonts = 1'b1;
                            cmd.dec_codes = stat.fonts_one;
                            state_next    = after_font(stat.fonts_one, stat.codes_one);
                        end else begin
                            state_next = drcs_pkg::PH_SKIP;
                        end
                    end
                    drcs_pkg::PH_DONE: begin
                        state_next = drcs_pkg::PH_DONE;
                    end
                    drcs_pkg::PH_FAIL: begin
                        state_next = drcs_pkg::PH_FAIL;
                    end
                    drcs_pkg::PH_CHECK: begin
                        state_next = drcs_pkg::PH_CHECK;
                    end
                    default: begin
                        state_next = drcs_pkg::PH_FAIL;
                    end
                endcase
                if (err) begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = drcs_pkg::KIND_ERR;
                    state_next   = drcs_pkg::PH_FAIL;
                end else if (stat.rem_last && ph != drcs_pkg::PH_FAIL
                             && ph != drcs_pkg::PH_HEIGHT) begin
                    // Last beat of the unit: report whether the lists completed.
                    cmd.out_load = 1'b1;
                    cmd.out_kind = (state_next == drcs_pkg::PH_DONE)
                                   ? drcs_pkg::KIND_OK : drcs_pkg::KIND_ERR;
                end
            end
        end
    end

endmodule

`default_nettype wire

FILE: tb/drcs_unit_tracker.sv
// Reference predictor and result checker for the DRCS font unit parser bench.
`timescale 1ns / 100ps

package drcs_unit_tracker_pkg;

    localparam logic [3:0]  MODE_PLAIN  = 4'd0;
    localparam logic [3:0]  MODE_GRADED = 4'd1;
    localparam int unsigned MAX_BPP     = 9;

    typedef struct packed {
        drcs_pkg::kind_t                  kind;
        logic [drcs_pkg::CODE_W-1:0]      code;
        logic [7:0]                       width;
        logic [7:0]                       height;
        logic [7:0]                       depth;
        logic [drcs_pkg::BPP_W-1:0]       bpp;
        logic [drcs_pkg::SIZE_W-1:0]      size;
        logic [drcs_pkg::LEN_W-1:0]       offset;
    } unit_report_t;

    // Smallest b with depth + 2 <= 2^b; plain fonts are always one bit deep.
    function automatic int unsigned pixel_bits(logic [3:0] mode, logic [7:0] depth);
        int unsigned b;
        b = 1;
        if (mode != MODE_PLAIN) begin
            while (b < MAX_BPP && int'(depth) + 2 > (1 << b)) b++;
        end
        return b;
    endfunction

    class drcs_unit_tracker;
        unit_report_t                 unit_reports[$];
        int unsigned                  failures;
        int unsigned                  n_records;
        int unsigned                  n_ok;
        int unsigned                  n_bad;

        drcs_pkg::phase_t             phase;
        logic [drcs_pkg::LEN_W-1:0]   remaining;
        logic [drcs_pkg::LEN_W-1:0]   position;
        logic [7:0]                   codes_left;
        logic [7:0]                   fonts_left;
        bit                           first_font;
        logic [drcs_pkg::CODE_W-1:0]  code;
        logic [3:0]                   mode;
        logic [7:0]                   depth;
        logic [7:0]                   width;
        logic [drcs_pkg::SIZE_W-1:0]  skip;
        bit                           failed;

        function new();
            clear();
            failures  = 0;
            n_records = 0;
            n_ok      = 0;
            n_bad     = 0;
        endfunction

        function void clear();
            phase      = drcs_pkg::PH_COUNT;
            remaining  = '0;
            position   = '0;
            codes_left = '0;
            fonts_left = '0;
            first_font = 1'b1;
            code       = '0;
            mode       = '0;
            depth      = '0;
            width      = '0;
            skip       = '0;
            failed     = 1'b0;
        endfunction

        function void queue_report(unit_report_t r);
            unit_reports.insert(unit_reports.size(), r);
        endfunction

        function void push_status(drcs_pkg::kind_t k);
            unit_report_t r;
            r      = '0;
            r.kind = k;
            queue_report(r);
        endfunction

        function void close_code();
            codes_left = codes_left - 8'd1;
            phase = (codes_left == 8'd0) ? drcs_pkg::PH_DONE : drcs_pkg::PH_CODE_HI;
        endfunction

        function void close_font();
            first_font = 1'b0;
            fonts_left = fonts_left - 8'd1;
            if (fonts_left == 8'd0) close_code();
            else phase = drcs_pkg::PH_MODE;
        endfunction

        // Advance the parser state by one accepted byte beat.
        function void take_byte(logic [7:0] b, logic first,
                                logic [drcs_pkg::LEN_W-1:0] len);
            logic [drcs_pkg::LEN_W-1:0] rem_after;
            bit                         err;
            int unsigned                bpp;
            int unsigned                size;
            unit_report_t               r;
            err = 1'b0;
            if (first) begin
                clear();
                remaining = len;
                if (len == '0) begin
                    failed = 1'b1;
                    push_status(drcs_pkg::KIND_ERR);
                    return;
                end
            end else if (remaining == '0) begin
                return;
            end
            rem_after = remaining - 1'b1;
            if (!failed) begin
                case (phase)
                    drcs_pkg::PH_COUNT: begin
                        codes_left = b;
                        phase = (b == 8'd0) ? drcs_pkg::PH_DONE : drcs_pkg::PH_CODE_HI;
                    end
                    drcs_pkg::PH_CODE_HI: begin
                        code  = {b, 8'h00};
                        phase = drcs_pkg::PH_CODE_LO;
                    end
                    drcs_pkg::PH_CODE_LO: begin
                        code  = {code[15:8], b};
                        phase = drcs_pkg::PH_NFONT;
                    end
                    drcs_pkg::PH_NFONT: begin
                        fonts_left = b;
                        first_font = 1'b1;
                        if (b == 8'd0) close_code();
                        else phase = drcs_pkg::PH_MODE;
                    end
                    drcs_pkg::PH_MODE: begin
                        mode  = b[3:0];
                        phase = (mode <= MODE_GRADED) ? drcs_pkg::PH_DEPTH
                                                      : drcs_pkg::PH_GEO0;
                    end
                    drcs_pkg::PH_DEPTH: begin
                        depth = b;
                        phase = drcs_pkg::PH_WIDTH;
                    end
                    drcs_pkg::PH_WIDTH: begin
                        width = b;
                        phase = drcs_pkg::PH_HEIGHT;
                    end
                    drcs_pkg::PH_HEIGHT: begin
                        if (width == 8'd0 || b == 8'd0) begin
                            err = 1'b1;
                        end else begin
                            bpp  = pixel_bits(mode, depth);
                            size = (int'(width) * int'(b) * bpp + 7) >> 3;
                            if (int'(rem_after) < size) begin
                                err = 1'b1;
                            end else begin
                                if (first_font) begin
                                    r.kind   = drcs_pkg::KIND_FONT;
                                    r.code   = code;
                                    r.width  = width;
                                    r.height = b;
                                    r.depth  = depth;
                                    r.bpp    = bpp[drcs_pkg::BPP_W-1:0];
                                    r.size   = size[drcs_pkg::SIZE_W-1:0];
                                    r.offset = position + 1'b1;
                                    queue_report(r);
                                end
                                first_font = 1'b0;
                                skip  = size[drcs_pkg::SIZE_W-1:0];
                                phase = drcs_pkg::PH_SKIP;
                            end
                        end
                    end
                    drcs_pkg::PH_SKIP: begin
                        skip = skip - 1'b1;
                        if (skip == '0) close_font();
                    end
                    drcs_pkg::PH_GEO0:    phase = drcs_pkg::PH_GEO1;
                    drcs_pkg::PH_GEO1:    phase = drcs_pkg::PH_GLEN_HI;
                    drcs_pkg::PH_GLEN_HI: begin
                        skip  = {1'b0, b, 8'h00};
                        phase = drcs_pkg::PH_GLEN_LO;
                    end
                    drcs_pkg::PH_GLEN_LO: begin
                        skip = {1'b0, skip[15:8], b};
                        if (int'(rem_after) < int'(skip)) err = 1'b1;
                        else if (skip == '0) close_font();
                        else phase = drcs_pkg::PH_SKIP;
                    end
                    default: ;
                endcase
                if (err) begin
                    failed = 1'b1;
                    push_status(drcs_pkg::KIND_ERR);
                end else if (rem_after == '0) begin
                    push_status((phase == drcs_pkg::PH_DONE) ? drcs_pkg::KIND_OK
                                                             : drcs_pkg::KIND_ERR);
                end
            end
            remaining = rem_after;
            position  = position + 1'b1;
        endfunction

        function void check_field(string label, logic [23:0] want, logic [23:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
                failures++;
            end
        endfunction

        // Compare one result beat against the oldest pending report.
        function void match_report(logic [drcs_pkg::M_TUSER_W-1:0] kind,
                                   logic [drcs_pkg::M_TDATA_W-1:0] data);
            unit_report_t want;
            if (unit_reports.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual kind %0h data %0h",
                         $time, kind, data);
                failures++;
                return;
            end
            want = unit_reports.pop_front();
            check_field("kind", 24'(want.kind), 24'(kind));
            check_field("char_code", 24'(want.code), 24'(data[15:0]));
            check_field("font_width", 24'(want.width), 24'(data[23:16]));
            check_field("font_height", 24'(want.height), 24'(data[31:24]));
            check_field("font_depth", 24'(want.depth), 24'(data[39:32]));
            check_field("bits_per_pixel", 24'(want.bpp), 24'(data[43:40]));
            check_field("bitmap_bytes", 24'(want.size), 24'(data[60:44]));
            check_field("bitmap_offset", want.offset, data[84:61]);
            check_field("pad", '0, 24'(data[87:85]));
            case (want.kind)
                drcs_pkg::KIND_FONT: n_records++;
                drcs_pkg::KIND_OK:   n_ok++;
                default:             n_bad++;
            endcase
        endfunction
    endclass

endpackage

FILE: tb/tb.sv
// Top-level bench for the DRCS font unit parser: stimulus, stalls and final verdict.
`timescale 1ns / 100ps

module tb;

    localparam int LEN_W       = drcs_pkg::LEN_W;
    localparam int S_TDATA_W   = drcs_pkg::S_TDATA_W;
    localparam int M_TDATA_W   = drcs_pkg::M_TDATA_W;
    localparam int M_TUSER_W   = drcs_pkg::M_TUSER_W;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_LIMIT = 100000;
    localparam int TAIL_CYCLES = 20;
    localparam int MAX_PATTERN = (255 * 255 * drcs_unit_tracker_pkg::MAX_BPP + 7) >> 3;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [M_TUSER_W-1:0]   m_tuser;

    drcs_unit_tracker_pkg::drcs_unit_tracker tracker;
    bit               idle_on;
    bit               hold_req;
    int unsigned      beats_sent;
    int unsigned      units_sent;

    drcs_font_unit_parser dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #40_000_000;
        $display("FAILURE");
        $finish;
    end

    // Receiver: random stall bursts, plus one long hold-off on request.
    initial begin
        int stall;
        stall    = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req && stall == 0) begin
                stall    = HOLD_CYCLES;
                hold_req = 1'b0;
            end else if (stall == 0 && idle_on && $urandom_range(0, 7) == 0) begin
                stall = $urandom_range(1, 7);
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                stall--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) tracker.match_report(m_tuser, m_tdata);
    end

    function automatic void add_byte(ref logic [7:0] q[$], input logic [7:0] v);
        q.insert(q.size(), v);
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic first,
                             input logic [LEN_W-1:0] len);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 7);
            @(negedge aclk);
            s_tvalid <= 1'b0;
            s_tdata  <= $urandom;
            s_tuser  <= 1'($urandom);
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {len, b};
        s_tuser  <= first;
        do @(posedge aclk); while (!s_tready);
        tracker.take_byte(b, first, len);
        beats_sent++;
    endtask

    // Send count beats of a unit declared len long; pad past the body with noise.
    task automatic send_unit(input logic [7:0] body[$], input logic [LEN_W-1:0] len,
                             input int count);
        logic [7:0] b;
        for (int i = 0; i < count; i++) begin
            b = (i < body.size()) ? body[i] : 8'($urandom);
            send_byte(b, i == 0, (i == 0) ? len : LEN_W'($urandom));
        end
        units_sent++;
    endtask

    // Well-formed unit body with random content and occasional bad headers.
    task automatic build_unit(output logic [7:0] body[$]);
        int         ncodes;
        int         nfonts;
        int         w;
        int         h;
        int         glen;
        int         size;
        logic [3:0] nib;
        logic [7:0] depth;
        body.delete();
        ncodes = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
        add_byte(body, 8'(ncodes));
        for (int c = 0; c < ncodes; c++) begin
            add_byte(body, 8'($urandom));
            add_byte(body, 8'($urandom));
            nfonts = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
            add_byte(body, 8'(nfonts));
            for (int f = 0; f < nfonts; f++) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3:    nib = drcs_unit_tracker_pkg::MODE_PLAIN;
                    4, 5, 6, 7:    nib = drcs_unit_tracker_pkg::MODE_GRADED;
                    default:       nib = 4'($urandom_range(2, 15));
                endcase
                add_byte(body, {4'($urandom), nib});
                if (nib <= drcs_unit_tracker_pkg::MODE_GRADED) begin
                    depth = 8'($urandom);
                    w = $urandom_range(1, 6);
                    h = $urandom_range(1, 6);
                    if ($urandom_range(0, 29) == 0) begin
                        w = $urandom_range(1, 255);
                        h = $urandom_range(1, 2);
                    end else if ($urandom_range(0, 29) == 0) begin
                        w = $urandom_range(1, 2);
                        h = $urandom_range(1, 255);
                    end
                    if ($urandom_range(0, 24) == 0) begin
                        if ($urandom_range(0, 1) == 0) w = 0;
                        else h = 0;
                    end
                    add_byte(body, depth);
                    add_byte(body, 8'(w));
                    add_byte(body, 8'(h));
                    size = (w * h * int'(drcs_unit_tracker_pkg::pixel_bits(nib, depth))
                            + 7) >> 3;
                    repeat (size) add_byte(body, 8'($urandom));
                end else begin
                    add_byte(body, 8'($urandom));
                    add_byte(body, 8'($urandom));
                    // Rarely claim far more data than any small unit holds.
                    if ($urandom_range(0, 19) == 0) begin
                        glen = $urandom_range(16'h8000, 16'hFFFF);
                        add_byte(body, glen[15:8]);
                        add_byte(body, glen[7:0]);
                    end else begin
                        glen = $urandom_range(0, 12);
                        add_byte(body, glen[15:8]);
                        add_byte(body, glen[7:0]);
                        repeat (glen) add_byte(body, 8'($urandom));
                    end
                end
            end
        end
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) add_byte(body, 8'($urandom));
        end
    endtask

    task automatic random_unit();
        logic [7:0]       body[$];
        logic [LEN_W-1:0] len;
        int               n;
        build_unit(body);
        n = body.size();
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12:
                send_unit(body, LEN_W'(n), n);
            13, 14: begin
                len = LEN_W'($urandom_range(1, n));
                send_unit(body, len, int'(len));
            end
            15: begin
                len = LEN_W'(n + $urandom_range(1, 5));
                send_unit(body, len, int'(len));
            end
            16, 17: begin
                // Start long, then abandon partway for the next unit.
                len = LEN_W'($urandom_range(n, 24'hFFFFFF));
                send_unit(body, len, $urandom_range(1, n));
            end
            18: begin
                send_byte(8'($urandom), 1'b1, '0);
                units_sent++;
            end
            default: begin
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom), 1'b0, LEN_W'($urandom));
            end
        endcase
    endtask

    initial begin
        logic [7:0] body[$];
        bit         pressure_done;
        int         waited;
        tracker       = new();
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = 1'b0;
        aresetn       = 1'b0;
        idle_on       = 1'b0;
        hold_req      = 1'b0;
        pressure_done = 1'b0;
        beats_sent    = 0;
        units_sent    = 0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: stray byte, zero length, empty unit, deepest graded font,
        // zero height, and a geometric length past the unit end.
        send_byte(8'hA5, 1'b0, '0);
        send_byte(8'h5A, 1'b1, '0);
        body = {8'h00};
        send_unit(body, 24'd1, 1);
        body = {8'h01, 8'hFF, 8'hFF, 8'h01, 8'hF1, 8'hFF, 8'h01, 8'h01, 8'hFF, 8'h00};
        send_unit(body, 24'd10, 10);
        body = {8'h01, 8'h00, 8'h00, 8'h01, 8'h00, 8'h07, 8'h05, 8'h00};
        send_unit(body, 24'd8, 8);
        body = {8'h01, 8'h12, 8'h34, 8'h02, 8'hF3, 8'h00, 8'h00, 8'hFF, 8'hFF};
        send_unit(body, 24'd9, 9);

        idle_on = 1'b1;
        while (beats_sent < 1000) begin
            if (!pressure_done && beats_sent >= 500) begin
                // Hold the receiver off while one-byte units keep producing status.
                hold_req = 1'b1;
                body = {8'h00};
                repeat (24) send_unit(body, 24'd1, 1);
                pressure_done = 1'b1;
            end
            random_unit();
        end
        idle_on = 1'b0;
        while (beats_sent < 1200) random_unit();

        // Largest pattern: 255 x 255 at nine bits per pixel; send only its header.
        body = {8'h01, 8'($urandom), 8'($urandom), 8'h01, 8'h31, 8'hFF, 8'hFF, 8'hFF};
        send_unit(body, LEN_W'(body.size() + MAX_PATTERN), body.size());

        @(negedge aclk);
        s_tvalid <= 1'b0;
        waited = 0;
        while (tracker.unit_reports.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (tracker.unit_reports.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, tracker.unit_reports.size());
            tracker.failures++;
        end
        $display("Ran %0d units in %0d byte beats: truncated, abandoned, zero-length,",
                 units_sent, beats_sent);
        $display("oversize and stray-byte cases; saw %0d font records, %0d ok, %0d errors",
                 tracker.n_records, tracker.n_ok, tracker.n_bad);
        if (tracker.failures == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
